>>> rtl/met_pkg.sv
// shared constants and types for the mesh edge table
`timescale 1ns / 1ps
package met_pkg;
  localparam int MAX_VERTICES_D    = 1024;
  localparam int MAX_EDGES_D       = 4096;
  localparam int SLOTS_PER_BLOCK_D = 8;
  localparam int MAX_BLOCKS_D      = 1024;

  localparam int VID_W  = 16;
  localparam int EDGE_W = 12;
  localparam int ST_W   = 2;

  localparam logic [ST_W-1:0] ST_OK        = 2'd0;
  localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL      = 2'd2;
  localparam logic [ST_W-1:0] ST_RANGE     = 2'd3;

  localparam logic FUNC_LOOKUP = 1'b0;
  localparam logic FUNC_INSERT = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic load;       // capture request
    logic rd_bucket;  // read bucket tables
    logic rd_slot;    // read slot and link of current position
    logic rd_ends;    // read endpoints of fetched edge
    logic step;       // advance walk position
    logic do_insert;  // commit insert writes
    logic emit;       // drive result
    logic [ST_W-1:0] st;
    logic use_edge;   // result edge from datapath, else all ones
    logic edge_src;   // 1: walk hit edge, 0: insert edge
  } met_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clearing;   // bucket counts being cleared after reset
    logic range_err;
    logic is_insert;
    logic bvalid;
    logic walk_done;
    logic hit;
    logic edges_full;
    logic need_block;
    logic blocks_full;
  } met_stat_t;
endpackage

>>> rtl/mesh_edge_table.sv
// top level of the mesh edge table: controller plus datapath
// one request at a time; the next transfer can be taken in the cycle after the result strobe
// the walk reads one slot, then the endpoint pair of its edge, then compares, for each slot
// rst_n synchronous active low clears counters, then busy while the bucket counts are
// cleared; results cannot be stalled, out_valid lasts one cycle
`timescale 1ns / 1ps
module mesh_edge_table #(
  parameter int MAX_VERTICES    = met_pkg::MAX_VERTICES_D,
  parameter int MAX_EDGES       = met_pkg::MAX_EDGES_D,
  parameter int SLOTS_PER_BLOCK = met_pkg::SLOTS_PER_BLOCK_D,
  parameter int MAX_BLOCKS      = met_pkg::MAX_BLOCKS_D
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic                        in_func,
  input  logic [met_pkg::VID_W-1:0]   in_vertex_a,
  input  logic [met_pkg::VID_W-1:0]   in_vertex_b,
  output logic                        out_valid,
  output logic [met_pkg::EDGE_W-1:0]  out_edge_number,
  output logic [met_pkg::ST_W-1:0]    out_status
);
  import met_pkg::*;

  met_cmd_t  cmd;   // controller commands
  met_stat_t stat;  // datapath status

  // sequencer: one transfer in, one result out
  met_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .stat(stat), .cmd(cmd)
  );

  // bucket tables, slot and endpoint memories
  met_datapath #(
    .MAX_VERTICES(MAX_VERTICES), .MAX_EDGES(MAX_EDGES),
    .SLOTS_PER_BLOCK(SLOTS_PER_BLOCK), .MAX_BLOCKS(MAX_BLOCKS)
  ) u_dp (
    .clk(clk), .rst_n(rst_n), .in_func(in_func),
    .in_vertex_a(in_vertex_a), .in_vertex_b(in_vertex_b),
    .cmd(cmd), .stat(stat), .out_edge_number(out_edge_number),
    .out_status(out_status), .out_valid(out_valid)
  );
endmodule

>>> rtl/met_datapath.sv
// storage and compare datapath of the mesh edge table
`timescale 1ns / 1ps
module met_datapath #(
  parameter int MAX_VERTICES    = met_pkg::MAX_VERTICES_D,
  parameter int MAX_EDGES       = met_pkg::MAX_EDGES_D,
  parameter int SLOTS_PER_BLOCK = met_pkg::SLOTS_PER_BLOCK_D,
  parameter int MAX_BLOCKS      = met_pkg::MAX_BLOCKS_D
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_func,
  input  logic [met_pkg::VID_W-1:0]         in_vertex_a,
  input  logic [met_pkg::VID_W-1:0]         in_vertex_b,
  input  met_pkg::met_cmd_t                 cmd,
  output met_pkg::met_stat_t                stat,
  output logic [met_pkg::EDGE_W-1:0]        out_edge_number,
  output logic [met_pkg::ST_W-1:0]          out_status,
  output logic                              out_valid
);
  import met_pkg::*;

  localparam int VX_W  = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int EI_W  = $clog2(MAX_EDGES);
  localparam int EC_W  = EI_W + 1;
  localparam int BI_W  = $clog2(MAX_BLOCKS);
  localparam int BC_W  = BI_W + 1;
  localparam int SP_W  = (SLOTS_PER_BLOCK > 1) ? $clog2(SLOTS_PER_BLOCK) : 1;
  localparam int TF_W  = $clog2(SLOTS_PER_BLOCK + 1);
  localparam int SA_W  = $clog2(MAX_BLOCKS * SLOTS_PER_BLOCK);
  localparam int SUM_W = VID_W + 1;

  // a bucket is valid when its entry count is nonzero
  logic [BI_W-1:0] bfirst_mem [MAX_VERTICES];
  logic [BI_W-1:0] blast_mem  [MAX_VERTICES];
  logic [EC_W-1:0] bcount_mem [MAX_VERTICES];
  logic [TF_W-1:0] tfill_mem  [MAX_VERTICES];
  logic [BI_W-1:0] link_mem   [MAX_BLOCKS];
  logic [EI_W-1:0] slot_mem   [MAX_BLOCKS*SLOTS_PER_BLOCK];
  logic [2*VID_W-1:0] ends_mem [MAX_EDGES];

  logic            clearing_r;
  logic [VX_W-1:0] clr_r;
  logic            func_r;
  logic [VID_W-1:0] a_r, b_r;
  logic [VX_W-1:0] lo_r;
  logic [SUM_W-1:0] sum_r;
  logic            range_r;
  logic [EC_W-1:0] edge_count_r;
  logic [BC_W-1:0] blocks_used_r;
  logic [BI_W-1:0] blast_r;
  logic [EC_W-1:0] bcount_r;
  logic [TF_W-1:0] tfill_r;
  logic [EC_W-1:0] k_r;
  logic [SP_W-1:0] pos_r;
  logic [BI_W-1:0] blk_r;
  logic [EI_W-1:0] slot_q_r;
  logic [BI_W-1:0] link_q_r;
  logic [2*VID_W-1:0] ends_q_r;
  logic [EI_W-1:0] cand_r;
  logic [EDGE_W-1:0] oedge_r;
  logic [ST_W-1:0] ost_r;
  logic            ovalid_r;

  logic [VID_W-1:0] lo_full, hi_full;
  logic [SUM_W-1:0] esum;
  logic             bv;
  logic             need_blk;
  logic [SA_W-1:0]  rd_sa, wr_sa;
  logic [SP_W-1:0]  wr_pos;

  assign lo_full = (in_vertex_a < in_vertex_b) ? in_vertex_a : in_vertex_b;
  assign hi_full = (in_vertex_a < in_vertex_b) ? in_vertex_b : in_vertex_a;
  assign esum = {1'b0, ends_q_r[VID_W-1:0]} + {1'b0, ends_q_r[2*VID_W-1:VID_W]};
  assign bv = (bcount_r != '0);
  // tail block full or no chain yet
  assign need_blk = !bv || (32'(tfill_r) == SLOTS_PER_BLOCK);
  assign rd_sa = SA_W'(blk_r) * SA_W'(SLOTS_PER_BLOCK) + SA_W'(pos_r);
  assign wr_pos = need_blk ? '0 : tfill_r[SP_W-1:0];
  assign wr_sa = SA_W'(need_blk ? blocks_used_r[BI_W-1:0] : blast_r)
                 * SA_W'(SLOTS_PER_BLOCK) + SA_W'(wr_pos);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r  <= in_func;
      a_r     <= in_vertex_a;
      b_r     <= in_vertex_b;
      lo_r    <= lo_full[VX_W-1:0];
      sum_r   <= {1'b0, in_vertex_a} + {1'b0, in_vertex_b};
      range_r <= (32'(hi_full) >= 32'(MAX_VERTICES));
    end
    if (cmd.rd_bucket) begin
      blast_r  <= blast_mem[lo_r];
      bcount_r <= bcount_mem[lo_r];
      tfill_r  <= tfill_mem[lo_r];
    end
    if (cmd.rd_bucket) begin
      k_r   <= '0;
      pos_r <= '0;
    end else if (cmd.step) begin
      k_r <= k_r + 1'b1;
      if (32'(pos_r) == SLOTS_PER_BLOCK - 1) begin
        pos_r <= '0;
        blk_r <= link_q_r;
      end else begin
        pos_r <= pos_r + 1'b1;
      end
    end
    if (cmd.rd_bucket) blk_r <= bfirst_mem[lo_r];
    if (cmd.rd_slot) begin
      slot_q_r <= slot_mem[rd_sa];
      link_q_r <= link_mem[blk_r];
    end
    if (cmd.rd_ends) begin
      ends_q_r <= ends_mem[slot_q_r];
      cand_r   <= slot_q_r;
    end
    // clearing pass after reset empties every bucket
    if (clearing_r) bcount_mem[clr_r] <= '0;
    else if (cmd.do_insert) bcount_mem[lo_r] <= bcount_r + 1'b1;
    if (cmd.do_insert) begin
      slot_mem[wr_sa] <= edge_count_r[EI_W-1:0];
      ends_mem[edge_count_r[EI_W-1:0]] <= {b_r, a_r};
      tfill_mem[lo_r] <= need_blk ? TF_W'(1) : tfill_r + 1'b1;
      if (need_blk) begin
        blast_mem[lo_r] <= blocks_used_r[BI_W-1:0];
        if (!bv) bfirst_mem[lo_r] <= blocks_used_r[BI_W-1:0];
      end
    end
    if (cmd.do_insert && need_blk && bv) link_mem[blast_r] <= blocks_used_r[BI_W-1:0];
    if (cmd.emit) begin
      oedge_r <= !cmd.use_edge ? '1 :
                 cmd.edge_src ? EDGE_W'(cand_r) : EDGE_W'(edge_count_r);
      ost_r   <= cmd.st;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r    <= 1'b1;
      clr_r         <= '0;
      edge_count_r  <= '0;
      blocks_used_r <= '0;
      ovalid_r      <= 1'b0;
    end else begin
      ovalid_r <= cmd.emit;
      if (clearing_r) begin
        clr_r <= clr_r + 1'b1;
        if (32'(clr_r) == MAX_VERTICES - 1) clearing_r <= 1'b0;
      end
      if (cmd.do_insert) begin
        edge_count_r    <= edge_count_r + 1'b1;
        if (need_blk) blocks_used_r <= blocks_used_r + 1'b1;
      end
    end
  end

  assign stat.clearing    = clearing_r;
  assign stat.range_err   = range_r;
  assign stat.is_insert   = (func_r == FUNC_INSERT);
  assign stat.bvalid      = bv;
  assign stat.walk_done   = (k_r >= bcount_r);
  assign stat.hit         = (esum == sum_r);
  assign stat.edges_full  = (32'(edge_count_r) >= MAX_EDGES);
  assign stat.need_block  = need_blk;
  assign stat.blocks_full = (32'(blocks_used_r) >= MAX_BLOCKS);

  assign out_edge_number = oedge_r;
  assign out_status      = ost_r;
  assign out_valid       = ovalid_r;
endmodule

>>> rtl/met_ctrl.sv
// sequencing state machine of the mesh edge table
`timescale 1ns / 1ps
module met_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  met_pkg::met_stat_t  stat,
  output met_pkg::met_cmd_t   cmd
);
  import met_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CHECK  = 3'd1;
  localparam logic [2:0] S_BUCKET = 3'd2;
  localparam logic [2:0] S_SLOT   = 3'd3;
  localparam logic [2:0] S_ENDS   = 3'd4;
  localparam logic [2:0] S_CMP    = 3'd5;
  localparam logic [2:0] S_INS    = 3'd6;
  localparam logic [2:0] S_DONE   = 3'd7;

  logic [2:0] state_r, state_nxt;

  always_comb begin
    cmd = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start && !stat.clearing) begin
          cmd.load = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.rd_bucket = 1'b1;
        if (stat.range_err) begin
          cmd.emit = 1'b1;
          cmd.st = ST_RANGE;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_BUCKET;
        end
      end
      S_BUCKET: begin
        if (stat.is_insert) begin
          state_nxt = S_INS;
        end else if (!stat.bvalid || stat.walk_done) begin
          cmd.emit = 1'b1;
          cmd.st = ST_NOT_FOUND;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_SLOT;
        end
      end
      S_SLOT: begin
        cmd.rd_slot = 1'b1;
        state_nxt = S_ENDS;
      end
      S_ENDS: begin
        cmd.rd_ends = 1'b1;
        cmd.step = 1'b1;
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (stat.hit) begin
          cmd.emit = 1'b1;
          cmd.st = ST_OK;
          cmd.use_edge = 1'b1;
          cmd.edge_src = 1'b1;
          state_nxt = S_DONE;
        end else if (stat.walk_done) begin
          cmd.emit = 1'b1;
          cmd.st = ST_NOT_FOUND;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_SLOT;
        end
      end
      S_INS: begin
        cmd.emit = 1'b1;
        if (stat.edges_full || (stat.need_block && stat.blocks_full)) begin
          cmd.st = ST_FULL;
        end else begin
          cmd.do_insert = 1'b1;
          cmd.st = ST_OK;
          cmd.use_edge = 1'b1;
        end
        state_nxt = S_DONE;
      end
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  assign busy = (state_r != S_IDLE) || stat.clearing;

  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> state_r == S_DONE) else $error("emit not followed by done");
  a_insert_ok: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.do_insert |-> cmd.emit && cmd.st == ST_OK) else $error("insert without ok");
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> !busy) else $error("load while busy");
endmodule

>>> sim/tb_top.sv
// self-checking testbench for the mesh edge table with its own edge table predictor
`timescale 1ns / 1ps
module tb_top;
  import met_pkg::*;

  // result fields of one transfer
  typedef struct packed {
    logic [EDGE_W-1:0] edge_num;
    logic [ST_W-1:0]   st;
  } edge_reply_t;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic              in_func;
  logic [VID_W-1:0]  in_vertex_a;
  logic [VID_W-1:0]  in_vertex_b;
  logic              out_valid;
  logic [EDGE_W-1:0] out_edge_number;
  logic [ST_W-1:0]   out_status;

  mesh_edge_table DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_func(in_func), .in_vertex_a(in_vertex_a), .in_vertex_b(in_vertex_b),
    .out_valid(out_valid), .out_edge_number(out_edge_number), .out_status(out_status)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // shadow copy of the table state
  bit               bkt_valid [MAX_VERTICES_D];
  int               bkt_first [MAX_VERTICES_D];
  int               bkt_last  [MAX_VERTICES_D];
  int               bkt_count [MAX_VERTICES_D];
  int               blk_next  [MAX_BLOCKS_D];
  int               blk_slot  [MAX_BLOCKS_D*SLOTS_PER_BLOCK_D];
  logic [31:0]      edge_ends [MAX_EDGES_D];
  int               edges_stored;
  int               blocks_taken;

  edge_reply_t      pending_replies[$];  // expected results in order
  logic [31:0]      known_edges[$];      // pairs inserted so far, for lookups that hit
  int               n_errors;
  int               gap_left;

  // work out the reply of one request and update the shadow table
  function automatic edge_reply_t table_apply(logic f, logic [VID_W-1:0] a,
                                              logic [VID_W-1:0] b);
    int lo, hi, sum, blk, cnt, e;
    bit fresh;
    edge_reply_t r;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    sum = a + b;
    r.edge_num = '1;
    // out of range vertex wins over everything
    if (hi >= MAX_VERTICES_D) begin
      r.st = ST_RANGE;
      return r;
    end
    if (f == FUNC_LOOKUP) begin
      r.st = ST_NOT_FOUND;
      if (!bkt_valid[lo]) return r;
      blk = bkt_first[lo];
      // walk the chain in insertion order, first match wins
      for (int k = 0; k < bkt_count[lo]; k++) begin
        if (k != 0 && k % SLOTS_PER_BLOCK_D == 0) blk = blk_next[blk];
        e = blk_slot[blk*SLOTS_PER_BLOCK_D + k % SLOTS_PER_BLOCK_D];
        if (edge_ends[e][15:0] + edge_ends[e][31:16] == sum) begin
          r.edge_num = e[EDGE_W-1:0];
          r.st = ST_OK;
          return r;
        end
      end
      return r;
    end
    // insert: edge table full, then block pool full
    r.st = ST_FULL;
    if (edges_stored >= MAX_EDGES_D) return r;
    cnt = bkt_valid[lo] ? bkt_count[lo] : 0;
    fresh = !bkt_valid[lo] || (cnt % SLOTS_PER_BLOCK_D) == 0;
    if (fresh && blocks_taken >= MAX_BLOCKS_D) return r;
    if (fresh) begin
      blk_next[blocks_taken] = 0;
      if (!bkt_valid[lo]) begin
        bkt_valid[lo] = 1'b1;
        bkt_first[lo] = blocks_taken;
        cnt = 0;
      end else begin
        blk_next[bkt_last[lo]] = blocks_taken;
      end
      bkt_last[lo] = blocks_taken;
      blocks_taken++;
    end
    blk_slot[bkt_last[lo]*SLOTS_PER_BLOCK_D + cnt % SLOTS_PER_BLOCK_D] = edges_stored;
    bkt_count[lo] = cnt + 1;
    edge_ends[edges_stored] = {b, a};
    known_edges.push_back({b, a});
    r.edge_num = edges_stored[EDGE_W-1:0];
    r.st = ST_OK;
    edges_stored++;
    return r;
  endfunction

  // one request transfer; start stays high so a burst runs without a gap
  task automatic send_request(logic f, logic [VID_W-1:0] a, logic [VID_W-1:0] b);
    @(negedge clk);
    start       <= 1'b1;
    in_func     <= f;
    in_vertex_a <= a;
    in_vertex_b <= b;
    do @(posedge clk); while (busy);
    pending_replies.push_back(table_apply(f, a, b));
  endtask

  task automatic idle_cycles(int n);
    @(negedge clk);
    start <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  // random burst shaping: idle between bursts of random length
  task automatic maybe_pause();
    if (gap_left > 0) begin
      gap_left--;
      return;
    end
    gap_left = $urandom_range(0, 12);
    if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 8));
  endtask

  task automatic drain();
    idle_cycles(1);
    while (pending_replies.size() != 0) @(posedge clk);
  endtask

  // result checker: one transfer per strobe, cannot be held off
  always @(posedge clk) begin
    edge_reply_t want;
    if (rst_n && out_valid) begin
      if (pending_replies.size() == 0) begin
        $display("%0t: unexpected result edge %0d status %0d", $time,
                 out_edge_number, out_status);
        n_errors++;
      end else begin
        want = pending_replies.pop_front();
        if (out_edge_number !== want.edge_num) begin
          $display("%0t: edge_number expected %0d actual %0d", $time,
                   want.edge_num, out_edge_number);
          n_errors++;
        end
        if (out_status !== want.st) begin
          $display("%0t: status expected %0d actual %0d", $time,
                   want.st, out_status);
          n_errors++;
        end
      end
    end
  end

  // empty buckets, range errors, duplicates, chain that crosses a block
  task automatic test_directed();
    send_request(FUNC_LOOKUP, 16'd5, 16'd6);
    send_request(FUNC_INSERT, 16'd0, 16'd0);
    send_request(FUNC_LOOKUP, 16'd0, 16'd0);
    send_request(FUNC_LOOKUP, 16'd0, 16'd1);
    send_request(FUNC_INSERT, 16'd1024, 16'd0);
    send_request(FUNC_LOOKUP, 16'd0, 16'd1024);
    send_request(FUNC_INSERT, 16'hFFFF, 16'hFFFF);
    send_request(FUNC_LOOKUP, 16'hFFFF, 16'h0000);
    send_request(FUNC_INSERT, 16'd1023, 16'd1023);
    send_request(FUNC_LOOKUP, 16'd1023, 16'd1023);
    send_request(FUNC_INSERT, 16'd3, 16'd7);
    send_request(FUNC_INSERT, 16'd7, 16'd3);
    send_request(FUNC_LOOKUP, 16'd7, 16'd3);
    for (int k = 0; k < 9; k++) send_request(FUNC_INSERT, 16'd2, 16'(10 + k));
    send_request(FUNC_LOOKUP, 16'd18, 16'd2);
    send_request(FUNC_LOOKUP, 16'd2, 16'd19);
    drain();
  endtask

  // mixed traffic over a narrow vertex range so buckets grow deep
  task automatic test_random_traffic();
    logic [31:0] pick;
    logic [VID_W-1:0] a, b;
    int span;
    for (int n = 0; n < 200; n++) begin
      maybe_pause();
      // one hold-off until everything has drained
      if (n == 100) drain();
      span = ($urandom_range(0, 3) == 0) ? MAX_VERTICES_D - 1 : 63;
      a = VID_W'($urandom_range(0, span));
      b = VID_W'($urandom_range(0, span));
      case ($urandom_range(0, 19))
        0: send_request(1'($urandom_range(0, 1)), VID_W'($urandom), VID_W'($urandom));
        1, 2, 3, 4, 5, 6, 7, 8: begin
          pick = known_edges[$urandom_range(0, known_edges.size() - 1)];
          if ($urandom_range(0, 1)) send_request(FUNC_LOOKUP, pick[15:0], pick[31:16]);
          else send_request(FUNC_LOOKUP, pick[31:16], pick[15:0]);
        end
        9, 10, 11: send_request(FUNC_LOOKUP, a, b);
        default: send_request(FUNC_INSERT, a, b);
      endcase
    end
    drain();
  endtask

  // open a bucket on every unused vertex until the block pool fills up
  task automatic test_fill_table();
    logic [31:0] pick;
    for (int v = 0; v < MAX_VERTICES_D; v++) begin
      if (blocks_taken < MAX_BLOCKS_D && !bkt_valid[v]) begin
        if ($urandom_range(0, 31) == 0) maybe_pause();
        send_request(FUNC_INSERT, VID_W'(v), VID_W'(v));
      end
    end
    // block pool is full now: inserts that need a block are refused
    for (int k = 0; k < 8; k++) begin
      send_request(FUNC_INSERT, VID_W'($urandom_range(0, 63)),
                   VID_W'($urandom_range(0, 63)));
      pick = known_edges[$urandom_range(0, known_edges.size() - 1)];
      send_request(FUNC_LOOKUP, pick[31:16], pick[15:0]);
    end
    drain();
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_func = FUNC_LOOKUP;
    in_vertex_a = '0;
    in_vertex_b = '0;
    n_errors = 0;
    gap_left = 0;
    edges_stored = 0;
    blocks_taken = 0;
    foreach (bkt_valid[i]) bkt_valid[i] = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_random_traffic();
    test_fill_table();
    repeat (40) @(posedge clk);
    if (n_errors == 0 && pending_replies.size() == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

  // watchdog
  initial begin
    #30ms;
    $display("*** FAILED ***");
    $finish;
  end
endmodule
